// ===== design/srt_pkg.sv =====
// Shared types and constants for the search result table.
package srt_pkg;

  localparam int unsigned SLOTS   = 4096;
  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned SCORE_W = 24;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned BOUND_W = 2;
  localparam int unsigned COORD_W = 3;
  localparam int unsigned MOVE_W  = 4 * COORD_W;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

  localparam logic ACT_PROBE = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } srt_state_e;

  // Move packing: from_col in the low bits, to_row in the high bits.
  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [BOUND_W-1:0]        bound;
    logic                      has_move;
    logic [MOVE_W-1:0]         move;
  } slot_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic lookup;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctrl_status_t;

  typedef struct packed {
    logic                      cutoff;
    logic signed [SCORE_W-1:0] cut_score;
    logic                      key_matched;
    logic                      found_move;
    logic [MOVE_W-1:0]         move;
    logic                      written;
  } result_t;

endpackage

// ===== design/srt_ctrl.sv =====
// Controller state machine: clearing pass, request accept and lookup sequencing.
module srt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  srt_pkg::ctrl_status_t status_i,
  output srt_pkg::ctrl_cmd_t    cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);
  import srt_pkg::*;

  srt_state_e state_q, state_d;
  logic       done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
    done_d = cmd_o.lookup;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  a_done_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_LOOK))
    else $error("result strobe without a preceding lookup");
  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && status_i.clear_last) |=> state_q == ST_IDLE)
    else $error("clearing pass did not end on its last slot");
  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> (state_q == ST_LOOK && busy_o))
    else $error("accepted transfer did not start a lookup");
`endif

endmodule

// ===== design/srt_datapath.sv =====
// Datapath: slot memory, request register, replace decision and probe evaluation.
module srt_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srt_pkg::ctrl_cmd_t                  cmd_i,
  output srt_pkg::ctrl_status_t               status_o,
  input  logic                                action_i,
  input  logic [srt_pkg::KEY_W-1:0]           key_i,
  input  logic [srt_pkg::DEPTH_W-1:0]         depth_i,
  input  logic signed [srt_pkg::SCORE_W-1:0]  score_i,
  input  logic [srt_pkg::BOUND_W-1:0]         bound_kind_i,
  input  logic signed [srt_pkg::SCORE_W-1:0]  alpha_i,
  input  logic signed [srt_pkg::SCORE_W-1:0]  beta_i,
  input  logic                                has_move_i,
  input  logic [srt_pkg::MOVE_W-1:0]          move_i,
  output srt_pkg::result_t                    result_o
);
  import srt_pkg::*;

  slot_t mem_q [SLOTS];
  slot_t rd_q;

  logic [IDX_W-1:0] clr_cnt_q;

  logic                      act_q;
  logic [KEY_W-1:0]          key_q;
  logic [DEPTH_W-1:0]        depth_q;
  logic signed [SCORE_W-1:0] score_q;
  logic [BOUND_W-1:0]        bound_q;
  logic signed [SCORE_W-1:0] alpha_q;
  logic signed [SCORE_W-1:0] beta_q;
  logic                      has_move_q;
  logic [MOVE_W-1:0]         move_q;

  result_t result_q, result_d;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;
  logic             replace;
  logic             match;
  logic             deep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign status_o.clear_last = (clr_cnt_q == {IDX_W{1'b1}});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q      <= action_i;
      key_q      <= key_i;
      depth_q    <= depth_i;
      score_q    <= score_i;
      bound_q    <= bound_kind_i;
      alpha_q    <= alpha_i;
      beta_q     <= beta_i;
      has_move_q <= has_move_i;
      move_q     <= move_i;
    end
  end

  // The slot is read at accept and written in the lookup state, before any next read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q <= mem_q[key_i[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  assign replace = (rd_q.key == '0) || (rd_q.depth <= depth_q);
  assign match   = (key_q != '0) && (rd_q.key == key_q);
  assign deep    = (rd_q.depth >= depth_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = key_q[IDX_W-1:0];
    wr_data = '0;
    if (cmd_i.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
    end else if (cmd_i.lookup && act_q == ACT_STORE && replace) begin
      wr_en            = 1'b1;
      wr_data.key      = key_q;
      wr_data.score    = score_q;
      wr_data.depth    = depth_q;
      wr_data.bound    = bound_q;
      wr_data.has_move = has_move_q;
      wr_data.move     = has_move_q ? move_q : '0;
    end
  end

  always_comb begin
    result_d = '0;
    if (act_q == ACT_STORE) begin
      result_d.written = replace;
    end else if (match) begin
      result_d.key_matched = 1'b1;
      if (rd_q.has_move) begin
        result_d.found_move = 1'b1;
        result_d.move       = rd_q.move;
      end
      if (deep) begin
        case (rd_q.bound)
          BOUND_EXACT: begin
            result_d.cutoff    = 1'b1;
            result_d.cut_score = rd_q.score;
          end
          BOUND_UPPER: begin
            if (rd_q.score <= alpha_q) begin
              result_d.cutoff    = 1'b1;
              result_d.cut_score = alpha_q;
            end
          end
          BOUND_LOWER: begin
            if (rd_q.score >= beta_q) begin
              result_d.cutoff    = 1'b1;
              result_d.cut_score = beta_q;
            end
          end
          default: result_d.cutoff = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

`ifndef NO_ASSERTIONS
  a_write_only_when_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !cmd_i.clear) |-> (cmd_i.lookup && act_q == ACT_STORE))
    else $error("slot written outside a store lookup");
  a_store_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.lookup && act_q == ACT_STORE) |=>
      (!result_q.key_matched && !result_q.cutoff && !result_q.found_move))
    else $error("store transfer reported probe fields");
  a_cutoff_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |=> (!result_q.cutoff || result_q.key_matched))
    else $error("cutoff reported without a key match");
`endif

endmodule

// ===== design/search_result_table.sv =====
// Search result table: the result strobe rises on the edge that follows the accepting edge.
// The result is valid for the single cycle in which done_o is high and is taken at the
// edge that ends that cycle, one transfer at a time.
// The read then write of the slot memory means a new transfer waits until the previous one has left its lookup state.
// A new transfer may be accepted in the same cycle that the previous result is shown.
// After reset a clearing pass writes all 4096 slots to zero, holding busy high that long.
module search_result_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action_i,
  input  logic [srt_pkg::KEY_W-1:0]           key_i,
  input  logic [srt_pkg::DEPTH_W-1:0]         depth_i,
  input  logic signed [srt_pkg::SCORE_W-1:0]  score_i,
  input  logic [srt_pkg::BOUND_W-1:0]         bound_kind_i,
  input  logic signed [srt_pkg::SCORE_W-1:0]  alpha_i,
  input  logic signed [srt_pkg::SCORE_W-1:0]  beta_i,
  input  logic                                has_move_i,
  input  logic [srt_pkg::COORD_W-1:0]         from_col_i,
  input  logic [srt_pkg::COORD_W-1:0]         from_row_i,
  input  logic [srt_pkg::COORD_W-1:0]         to_col_i,
  input  logic [srt_pkg::COORD_W-1:0]         to_row_i,
  output logic                                done_o,
  output logic                                cutoff_o,
  output logic signed [srt_pkg::SCORE_W-1:0]  cut_score_o,
  output logic                                key_matched_o,
  output logic                                found_move_o,
  output logic [srt_pkg::COORD_W-1:0]         found_from_col_o,
  output logic [srt_pkg::COORD_W-1:0]         found_from_row_o,
  output logic [srt_pkg::COORD_W-1:0]         found_to_col_o,
  output logic [srt_pkg::COORD_W-1:0]         found_to_row_o,
  output logic                                written_o
);
  import srt_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  result_t      result;

  srt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  srt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .action_i     (action_i),
    .key_i        (key_i),
    .depth_i      (depth_i),
    .score_i      (score_i),
    .bound_kind_i (bound_kind_i),
    .alpha_i      (alpha_i),
    .beta_i       (beta_i),
    .has_move_i   (has_move_i),
    .move_i       ({to_row_i, to_col_i, from_row_i, from_col_i}),
    .result_o     (result)
  );

  assign cutoff_o         = result.cutoff;
  assign cut_score_o      = result.cut_score;
  assign key_matched_o    = result.key_matched;
  assign found_move_o     = result.found_move;
  assign found_from_col_o = result.move[COORD_W-1:0];
  assign found_from_row_o = result.move[2*COORD_W-1:COORD_W];
  assign found_to_col_o   = result.move[3*COORD_W-1:2*COORD_W];
  assign found_to_row_o   = result.move[4*COORD_W-1:3*COORD_W];
  assign written_o        = result.written;

endmodule
